// ===== sv/subtractive_lagged_random_generator_assert.svh =====
// Assertion macros used by the generator's controller.
`ifndef SUBTRACTIVE_LAGGED_RANDOM_GENERATOR_ASSERT_SVH
`define SUBTRACTIVE_LAGGED_RANDOM_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SLRG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SLRG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/slrg_pkg.sv =====
// Package: constants, command struct and helper functions of the generator.
`timescale 1ns / 1ps
`default_nettype none
package slrg_pkg;

    localparam int unsigned VALUE_W     = 30;
    localparam int unsigned SEED_W      = 28;
    localparam int unsigned PTR_W       = 6;
    localparam int unsigned TABLE_LEN   = 55;
    localparam int unsigned TABLE_DEPTH = 56;   // positions 1..55, entry 0 unused
    localparam int unsigned LAG_START   = 31;
    localparam int unsigned FILL_STRIDE = 21;
    localparam int unsigned FILL_STEPS  = 54;
    localparam int unsigned WARM_SPLIT  = 24;
    localparam int unsigned WARM_LAG    = 31;
    localparam int unsigned WARM_PASSES = 4;

    localparam logic [SEED_W-1:0]  SEED_BASE = 28'd161803398;
    localparam logic [VALUE_W:0]   MODULUS   = 31'd1000000000;

    // Controller to datapath commands; fill_step may come with warm_init and warm_wr with ptr_reset, others alone.
    typedef struct packed {
        logic load_seed;
        logic fill_top;
        logic fill_step;
        logic warm_init;
        logic warm_rd_a;
        logic warm_rd_b;
        logic warm_wr;
        logic ptr_reset;
        logic draw_rd_f;
        logic draw_rd_b;
        logic draw_wr;
    } slrg_cmd_t;

    // (a - b) mod one billion, both operands below the modulus
    function automatic logic [VALUE_W-1:0] sub_mod(input logic [VALUE_W-1:0] a,
                                                   input logic [VALUE_W-1:0] b);
        logic [VALUE_W:0] d;
        d = {1'b0, a} - {1'b0, b};
        if (d[VALUE_W])
        begin
            d = d + MODULUS;
        end
        return d[VALUE_W-1:0];
    endfunction

    // cyclic step over positions 1..55; anything out of range wraps to 1
    function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p >= PTR_W'(TABLE_LEN))
        begin
            r = PTR_W'(1);
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/slrg_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module slrg_ram #(
    parameter int unsigned DATA_W = 8,
    parameter int unsigned DEPTH  = 16
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [DATA_W-1:0]          wr_data,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic      [DATA_W-1:0]          rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== sv/slrg_dp.sv =====
// Datapath: lag table, index registers and modular subtractor.
`timescale 1ns / 1ps
`default_nettype none
module slrg_dp
    import slrg_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire slrg_cmd_t            cmd,
    input  wire logic [SEED_W-1:0]    seed,
    output logic      [VALUE_W-1:0]   value
);

    logic [VALUE_W-1:0] cur_reg, prev_reg, a_reg, value_reg;
    logic [PTR_W-1:0]   pos_reg, wi_reg, front_reg, back_reg;

    logic [SEED_W-1:0]  seed_sat;
    logic [PTR_W:0]     pos_sum;
    logic [PTR_W-1:0]   pos_next, partner, front_adv, back_adv;
    logic [VALUE_W-1:0] diff;

    logic               ram_we, ram_re;
    logic [PTR_W-1:0]   ram_waddr, ram_raddr;
    logic [VALUE_W-1:0] ram_wdata, ram_rdata;

    assign seed_sat  = (seed > SEED_BASE) ? SEED_BASE : seed;
    assign pos_sum   = {1'b0, pos_reg} + (PTR_W+1)'(FILL_STRIDE);
    assign pos_next  = (pos_sum >= (PTR_W+1)'(TABLE_LEN))
                     ? PTR_W'(pos_sum - (PTR_W+1)'(TABLE_LEN)) : pos_sum[PTR_W-1:0];
    // partner of position i in the warm-up: 1 + (i + 30) mod 55
    assign partner   = (wi_reg <= PTR_W'(WARM_SPLIT)) ? wi_reg + PTR_W'(WARM_LAG)
                                                      : wi_reg - PTR_W'(WARM_SPLIT);
    assign front_adv = ptr_advance(front_reg);
    assign back_adv  = ptr_advance(back_reg);
    assign diff      = sub_mod(a_reg, ram_rdata);

    always_comb
    begin
        priority if (cmd.warm_rd_a)
        begin
            ram_re    = 1'b1;
            ram_raddr = wi_reg;
        end
        else if (cmd.warm_rd_b)
        begin
            ram_re    = 1'b1;
            ram_raddr = partner;
        end
        else if (cmd.draw_rd_f)
        begin
            ram_re    = 1'b1;
            ram_raddr = front_adv;
        end
        else if (cmd.draw_rd_b)
        begin
            ram_re    = 1'b1;
            ram_raddr = back_adv;
        end
        else
        begin
            ram_re    = 1'b0;
            ram_raddr = '0;
        end
    end

    always_comb
    begin
        priority if (cmd.fill_top)
        begin
            ram_we    = 1'b1;
            ram_waddr = PTR_W'(TABLE_LEN);
            ram_wdata = cur_reg;
        end
        else if (cmd.fill_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = pos_reg;
            ram_wdata = prev_reg;
        end
        else if (cmd.warm_wr)
        begin
            ram_we    = 1'b1;
            ram_waddr = wi_reg;
            ram_wdata = diff;
        end
        else if (cmd.draw_wr)
        begin
            ram_we    = 1'b1;
            ram_waddr = front_reg;
            ram_wdata = diff;
        end
        else
        begin
            ram_we    = 1'b0;
            ram_waddr = '0;
            ram_wdata = '0;
        end
    end

    // pointers carry reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            back_reg  <= PTR_W'(LAG_START);
        end
        else
        begin
            if (cmd.ptr_reset)
            begin
                front_reg <= '0;
                back_reg  <= PTR_W'(LAG_START);
            end
            if (cmd.draw_rd_f)
            begin
                front_reg <= front_adv;
            end
            if (cmd.draw_rd_b)
            begin
                back_reg <= back_adv;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_seed)
        begin
            cur_reg  <= VALUE_W'(SEED_BASE - seed_sat);
            prev_reg <= VALUE_W'(1);
            pos_reg  <= PTR_W'(FILL_STRIDE);
        end
        if (cmd.fill_step)
        begin
            prev_reg <= sub_mod(cur_reg, prev_reg);
            cur_reg  <= prev_reg;
            pos_reg  <= pos_next;
        end
        if (cmd.warm_init)
        begin
            wi_reg <= PTR_W'(1);
        end
        if (cmd.warm_wr)
        begin
            wi_reg <= ptr_advance(wi_reg);
        end
        // first operand arrives in the cycle after its read
        if (cmd.warm_rd_b || cmd.draw_rd_b)
        begin
            a_reg <= ram_rdata;
        end
        if (cmd.draw_wr)
        begin
            value_reg <= diff;
        end
    end

    assign value = value_reg;

    slrg_ram #(
        .DATA_W (VALUE_W),
        .DEPTH  (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

endmodule
`default_nettype wire

// ===== sv/slrg_ctrl.sv =====
// Controller: sequences seeding, warm-up and draws, owns output valid.
`timescale 1ns / 1ps
`default_nettype none
module slrg_ctrl
    import slrg_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire logic      op,
    output logic           m_tvalid,
    input  wire logic      m_tready,
    output slrg_cmd_t      cmd
);

    `include "subtractive_lagged_random_generator_assert.svh"

    typedef enum logic [3:0] {
        IDLE,
        FILL_TOP,
        FILL,
        WARM_RA,
        WARM_RB,
        WARM_WR,
        DRAW_RF,
        DRAW_RB,
        DRAW_WR
    } state_t;

    state_t           state_reg, state_next;
    logic [PTR_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       pass_reg, pass_next;
    logic             seeded_reg, seeded_next;
    logic             out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pass_next      = pass_reg;
        seeded_next    = seeded_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        unique case (state_reg)
            IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_seed = 1'b1;
                    state_next    = (op || !seeded_reg) ? FILL_TOP : DRAW_RF;
                end
            end
            FILL_TOP:
            begin
                cmd.fill_top = 1'b1;
                cnt_next     = '0;
                state_next   = FILL;
            end
            FILL:
            begin
                cmd.fill_step = 1'b1;
                if (cnt_reg == PTR_W'(FILL_STEPS - 1))
                begin
                    cmd.warm_init = 1'b1;
                    cnt_next      = '0;
                    pass_next     = '0;
                    state_next    = WARM_RA;
                end
                else
                begin
                    cnt_next = cnt_reg + PTR_W'(1);
                end
            end
            WARM_RA:
            begin
                cmd.warm_rd_a = 1'b1;
                state_next    = WARM_RB;
            end
            WARM_RB:
            begin
                cmd.warm_rd_b = 1'b1;
                state_next    = WARM_WR;
            end
            WARM_WR:
            begin
                cmd.warm_wr = 1'b1;
                state_next  = WARM_RA;
                if (cnt_reg == PTR_W'(TABLE_LEN - 1))
                begin
                    cnt_next = '0;
                    if (pass_reg == 2'(WARM_PASSES - 1))
                    begin
                        cmd.ptr_reset = 1'b1;
                        seeded_next   = 1'b1;
                        state_next    = DRAW_RF;
                    end
                    else
                    begin
                        pass_next = pass_reg + 2'd1;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + PTR_W'(1);
                end
            end
            DRAW_RF:
            begin
                cmd.draw_rd_f = 1'b1;
                state_next    = DRAW_RB;
            end
            DRAW_RB:
            begin
                cmd.draw_rd_b = 1'b1;
                state_next    = DRAW_WR;
            end
            DRAW_WR:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    cmd.draw_wr    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            cnt_reg       <= '0;
            pass_reg      <= '0;
            seeded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pass_reg      <= pass_next;
            seeded_reg    <= seeded_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = out_valid_reg;

    `SLRG_ASSERT_IMP(a_fill_count, clk, rst_n, state_reg == FILL,
        cnt_reg <= PTR_W'(FILL_STEPS - 1), "fill counter past last stride step")
    `SLRG_ASSERT_IMP(a_draw_slot_free, clk, rst_n, cmd.draw_wr,
        !out_valid_reg || m_tready, "result overwrites an item not yet taken")
    `SLRG_ASSERT_NEXT(a_unseeded_fills, clk, rst_n, s_tvalid && s_tready && !seeded_reg,
        state_reg == FILL_TOP, "first item after reset skipped seeding")
    `SLRG_ASSERT_NEXT(a_warm_done, clk, rst_n, cmd.ptr_reset,
        seeded_reg && state_reg == DRAW_RF, "warm-up end did not start the draw")

endmodule
`default_nettype wire

// ===== sv/subtractive_lagged_random_generator.sv =====
// Top level: subtractive lagged random generator, modulus one billion.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | s_tuser[0] op, s_tdata[27:0] seed
//  m_*     | out | m_tvalid/m_tready  | m_tdata[29:0] value
//
//  A plain draw steps through accept, read front entry, read back entry,
//  subtract and write back; the single read port of the lag table puts the
//  two reads one after the other. A reseeding item (or the first item after
//  reset) runs one write of the top entry, 54 stride writes, then 4 x 55
//  warm-up updates, each two reads and a write, then the draw.
//  Reset is asynchronous, active low; the table itself is not cleared, as the
//  first item always seeds it. A stalled output holds the finished item in its
//  register; the next item is still accepted and waits in its final cycle.
`timescale 1ns / 1ps
`default_nettype none
module subtractive_lagged_random_generator
    import slrg_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // [27:0] seed, [31:28] zero
    input  wire logic [0:0]   s_tuser,   // [0] op: 0 draw, 1 reseed then draw
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic      [31:0]  m_tdata    // [29:0] value, [31:30] zero
);

    slrg_cmd_t          cmd;
    logic [VALUE_W-1:0] value;

    // sequencer: decides between plain draw and full reseed
    slrg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // table memory, pointers and modular subtract
    slrg_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .seed  (s_tdata[SEED_W-1:0]),
        .value (value)
    );

    assign m_tdata = {2'b00, value};

endmodule
`default_nettype wire
